### hw/rtl/wilke_mixing_contribution_unit_assert.svh
// Assertion macros shared by the Wilke mixing contribution unit.
`ifndef WILKE_MIXING_CONTRIBUTION_UNIT_ASSERT_SVH
`define WILKE_MIXING_CONTRIBUTION_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define WMC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define WMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/wmc_pkg.sv
// Package with the types and constants of the Wilke mixing contribution unit.
package wmc_pkg;

	localparam int MAX_SPECIES = 8;
	localparam int IDX_W = $clog2(MAX_SPECIES);
	localparam int CNT_W = $clog2(MAX_SPECIES + 1);
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VISC_FLOOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEN_FLOOR = 2'd2;

	localparam logic [5:0] SH_MOLE = 6'd32;
	localparam logic [5:0] SH_ROOT8 = 6'd35;
	localparam logic [5:0] SH_PHI = 6'd16;
	localparam logic [5:0] SH_NONE = 6'd0;
	localparam logic [63:0] ONE_Q16 = 64'h0000_0000_0001_0000;
	localparam logic [63:0] EIGHT_Q32 = 64'h0000_0008_0000_0000;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef struct packed {
		logic start;
		alu_op_t op;
		logic [63:0] a;
		logic [63:0] b;
		logic [5:0] shift;
	} alu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [127:0] result;
	} alu_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_START,
		ST_SUM_NEXT,
		ST_SUM_RD,
		ST_SUM_OP,
		ST_CHECK,
		ST_TGT_RD,
		ST_NI,
		ST_XI,
		ST_J_NEXT,
		ST_J_RD,
		ST_NJ,
		ST_XJ,
		ST_VRAT,
		ST_S,
		ST_GRAT,
		ST_G,
		ST_F,
		ST_T,
		ST_T2,
		ST_DRAT,
		ST_D,
		ST_PHI,
		ST_ACC,
		ST_QX,
		ST_MAG,
		ST_DONE
	} state_t;

endpackage

### hw/rtl/wmc_store.sv
// Species store: mass fraction, molar weight and viscosity per species slot.
module wmc_store (
	input  logic                      clk,
	input  logic                      we,
	input  logic [wmc_pkg::IDX_W-1:0] wr_addr,
	input  logic [15:0]               wr_fraction,
	input  logic [15:0]               wr_weight,
	input  logic [31:0]               wr_viscosity,
	input  logic [wmc_pkg::IDX_W-1:0] rd_addr,
	output logic [15:0]               rd_fraction,
	output logic [15:0]               rd_weight,
	output logic [31:0]               rd_viscosity
);
	import wmc_pkg::*;

	logic [15:0] fraction_mem [MAX_SPECIES];
	logic [15:0] weight_mem [MAX_SPECIES];
	logic [31:0] viscosity_mem [MAX_SPECIES];

	always_ff @(posedge clk) begin
		if (we) begin
			fraction_mem[wr_addr] <= wr_fraction;
			weight_mem[wr_addr] <= wr_weight;
			viscosity_mem[wr_addr] <= wr_viscosity;
		end
	end

	always_ff @(posedge clk) begin
		rd_fraction <= fraction_mem[rd_addr];
		rd_weight <= weight_mem[rd_addr];
		rd_viscosity <= viscosity_mem[rd_addr];
	end

endmodule

### hw/rtl/wmc_alu.sv
// Shared serial unit: shift-add multiply, restoring divide and integer square root.
module wmc_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  wmc_pkg::alu_req_t req,
	output wmc_pkg::alu_rsp_t rsp
);
	import wmc_pkg::*;

	alu_op_t op_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [64:0] acc_q;
	logic [63:0] x_q;
	logic [63:0] y_q;
	logic [63:0] opnd_q;

	logic [6:0] steps;
	logic [64:0] mul_sum;
	logic [64:0] div_trial;
	logic div_ge;
	logic [64:0] sqrt_trial;
	logic [64:0] sqrt_test;
	logic sqrt_ge;

	always_comb begin
		unique case (req.op)
			ALU_MUL: steps = 7'd63;
			ALU_DIV: steps = 7'd63 + {1'b0, req.shift};
			ALU_SQRT: steps = 7'd31;
			default: steps = 7'd0;
		endcase
		mul_sum = acc_q + (x_q[0] ? {1'b0, opnd_q} : 65'd0);
		div_trial = {acc_q[63:0], x_q[63]};
		div_ge = div_trial >= {1'b0, opnd_q};
		sqrt_trial = {acc_q[62:0], x_q[63:62]};
		sqrt_test = {y_q[62:0], 2'b01};
		sqrt_ge = sqrt_trial >= sqrt_test;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= ALU_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= steps;
				op_q <= req.op;
			end else if (busy_q) begin
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			acc_q <= '0;
			y_q <= '0;
			if (req.op == ALU_MUL) begin
				x_q <= req.b;
				opnd_q <= req.a;
			end else begin
				x_q <= req.a;
				opnd_q <= req.b;
			end
		end else if (busy_q) begin
			unique case (op_q)
				ALU_MUL: begin
					acc_q <= {1'b0, mul_sum[64:1]};
					x_q <= {mul_sum[0], x_q[63:1]};
				end
				ALU_DIV: begin
					acc_q <= div_ge ? (div_trial - {1'b0, opnd_q}) : div_trial;
					x_q <= {x_q[62:0], 1'b0};
					y_q <= {y_q[62:0], div_ge};
				end
				ALU_SQRT: begin
					acc_q <= sqrt_ge ? (sqrt_trial - sqrt_test) : sqrt_trial;
					x_q <= {x_q[61:0], 2'b00};
					y_q <= {y_q[62:0], sqrt_ge};
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.result = (op_q == ALU_MUL) ? {acc_q[63:0], x_q} : {64'd0, y_q};

endmodule

### hw/rtl/wilke_mixing_contribution_unit.sv
// Top level of the Wilke mixing contribution unit: species loading and sequencer.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------------
//  in      | request   | in_valid/in_stall  | mass_fraction mol_weight viscosity
//          |           |                    | property_value last_species
//  out     | result    | out_valid/out_stall| contribution degenerate
//  cfg     | write     | cfg_we             | cfg_index cfg_data
//
// A request that is not the last of its cell is taken without a stall. The last request starts
// the sequencer, which runs every multiply, divide and square root through one serial unit
// at one bit (two radicand bits) a cycle: first the molar sum over every species, then the
// Wilke terms for each other species, and last the scaling of the property value.
// in_stall is high for the whole computation and while a result waits behind a full output
// register. Reset is asynchronous, active low, and clears the cell count and flags.
`include "wilke_mixing_contribution_unit_assert.svh"

module wilke_mixing_contribution_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [15:0]                   mass_fraction,
	input  logic [15:0]                   mol_weight,
	input  logic [31:0]                   viscosity,
	input  logic signed [31:0]            property_value,
	input  logic                          last_species,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [31:0]            contribution,
	output logic                          degenerate,
	input  logic                          cfg_we,
	input  logic [wmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);
	import wmc_pkg::*;

	state_t state_q, state_d;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic [2:0] tgt_q;
	logic [15:0] vf_q;
	logic [15:0] df_q;
	logic [CNT_W-1:0] cnt_q;
	logic ovf_q;
	logic [31:0] prop_q;
	logic [CNT_W-1:0] loop_q;
	logic op_run_q;
	logic out_valid_q;

	logic [63:0] sum_q;
	logic [15:0] mi_q;
	logic [31:0] mui_q;
	logic [63:0] xi_q;
	logic [63:0] den_q;
	logic [63:0] tmp_q;
	logic [63:0] xj_q;
	logic [63:0] s_q;
	logic [63:0] f_q;
	logic [63:0] t2_q;
	logic [31:0] res_q;
	logic deg_q;
	logic [31:0] contribution_q;
	logic degenerate_q;

	logic [15:0] st_fraction;
	logic [15:0] st_weight;
	logic [31:0] st_visc;

	logic accept;
	logic store_we;
	logic out_free;
	logic [CNT_W-1:0] tgt_ext;
	logic [15:0] w_eff;
	logic [15:0] vf_eff;
	logic [15:0] df_eff;
	logic [31:0] muj_eff;
	logic [63:0] den_eff;
	logic neg;
	logic [31:0] qmag;
	logic [63:0] mag;
	logic [31:0] sat;
	logic [31:0] signed_res;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign store_we = accept && (cnt_q < CNT_W'(MAX_SPECIES));
	assign out_free = !out_valid_q || !out_stall;
	assign tgt_ext = CNT_W'(tgt_q);

	assign w_eff = (st_weight == 16'd0) ? 16'd1 : st_weight;
	assign vf_eff = (vf_q == 16'd0) ? 16'd1 : vf_q;
	assign df_eff = (df_q == 16'd0) ? 16'd1 : df_q;
	assign muj_eff = (st_visc < {16'd0, vf_eff}) ? {16'd0, vf_eff} : st_visc;
	assign den_eff = (den_q < {48'd0, df_eff}) ? {48'd0, df_eff} : den_q;

	assign neg = prop_q[31];
	assign qmag = neg ? (~prop_q + 32'd1) : prop_q;
	assign mag = alu_rsp.result[63:0];
	assign sat = neg ? ((mag > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : mag[31:0])
		: ((mag > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0]);
	assign signed_res = neg ? (~sat + 32'd1) : sat;

	wmc_store u_store (
		.clk         (clk),
		.we          (store_we),
		.wr_addr     (cnt_q[IDX_W-1:0]),
		.wr_fraction (mass_fraction),
		.wr_weight   (mol_weight),
		.wr_viscosity(viscosity),
		.rd_addr     (loop_q[IDX_W-1:0]),
		.rd_fraction (st_fraction),
		.rd_weight   (st_weight),
		.rd_viscosity(st_visc)
	);

	wmc_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.rsp   (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		alu_req.start = 1'b0;
		alu_req.op = ALU_DIV;
		alu_req.a = '0;
		alu_req.b = '0;
		alu_req.shift = SH_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && last_species) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = ovf_q ? ST_DONE : ST_SUM_NEXT;
			end
			ST_SUM_NEXT: begin
				state_d = (loop_q == cnt_q) ? ST_CHECK : ST_SUM_RD;
			end
			ST_SUM_RD: begin
				state_d = ST_SUM_OP;
			end
			ST_SUM_OP: begin
				alu_req.a = {48'd0, st_fraction};
				alu_req.b = {48'd0, w_eff};
				alu_req.shift = SH_MOLE;
			end
			ST_CHECK: begin
				if ((sum_q == 64'd0) || (tgt_ext >= cnt_q)) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_TGT_RD;
				end
			end
			ST_TGT_RD: begin
				state_d = ST_NI;
			end
			ST_NI: begin
				alu_req.a = {48'd0, st_fraction};
				alu_req.b = {48'd0, w_eff};
				alu_req.shift = SH_MOLE;
			end
			ST_XI: begin
				alu_req.a = tmp_q;
				alu_req.b = sum_q;
				alu_req.shift = SH_MOLE;
			end
			ST_J_NEXT: begin
				priority if (loop_q == cnt_q) begin
					state_d = ST_QX;
				end else if (loop_q == tgt_ext) begin
					state_d = ST_J_NEXT;
				end else begin
					state_d = ST_J_RD;
				end
			end
			ST_J_RD: begin
				state_d = ST_NJ;
			end
			ST_NJ: begin
				alu_req.a = {48'd0, st_fraction};
				alu_req.b = {48'd0, w_eff};
				alu_req.shift = SH_MOLE;
			end
			ST_XJ: begin
				alu_req.a = tmp_q;
				alu_req.b = sum_q;
				alu_req.shift = SH_MOLE;
			end
			ST_VRAT: begin
				alu_req.a = {32'd0, mui_q};
				alu_req.b = {32'd0, muj_eff};
				alu_req.shift = SH_MOLE;
			end
			ST_S: begin
				alu_req.op = ALU_SQRT;
				alu_req.a = tmp_q;
			end
			ST_GRAT: begin
				alu_req.a = {48'd0, w_eff};
				alu_req.b = {48'd0, mi_q};
				alu_req.shift = SH_MOLE;
			end
			ST_G: begin
				alu_req.op = ALU_SQRT;
				alu_req.a = tmp_q;
			end
			ST_F: begin
				alu_req.op = ALU_SQRT;
				alu_req.a = {tmp_q[47:0], 16'd0};
			end
			ST_T: begin
				alu_req.op = ALU_MUL;
				alu_req.a = s_q;
				alu_req.b = f_q;
			end
			ST_T2: begin
				alu_req.op = ALU_MUL;
				alu_req.a = tmp_q;
				alu_req.b = tmp_q;
			end
			ST_DRAT: begin
				alu_req.a = {48'd0, mi_q};
				alu_req.b = {48'd0, w_eff};
				alu_req.shift = SH_ROOT8;
			end
			ST_D: begin
				alu_req.op = ALU_SQRT;
				alu_req.a = tmp_q + EIGHT_Q32;
			end
			ST_PHI: begin
				alu_req.a = t2_q;
				alu_req.b = tmp_q;
				alu_req.shift = SH_PHI;
			end
			ST_ACC: begin
				alu_req.op = ALU_MUL;
				alu_req.a = xj_q;
				alu_req.b = tmp_q;
			end
			ST_QX: begin
				alu_req.op = ALU_MUL;
				alu_req.a = {32'd0, qmag};
				alu_req.b = xi_q;
			end
			ST_MAG: begin
				alu_req.a = tmp_q;
				alu_req.b = den_eff;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		unique case (state_q)
			ST_SUM_OP, ST_NI, ST_XI, ST_NJ, ST_XJ, ST_VRAT, ST_S, ST_GRAT, ST_G, ST_F,
			ST_T, ST_T2, ST_DRAT, ST_D, ST_PHI, ST_ACC, ST_QX, ST_MAG: begin
				alu_req.start = !op_run_q;
				if (alu_rsp.done) begin
					unique case (state_q)
						ST_SUM_OP: state_d = ST_SUM_NEXT;
						ST_NI: state_d = ST_XI;
						ST_XI: state_d = ST_J_NEXT;
						ST_NJ: state_d = ST_XJ;
						ST_XJ: state_d = ST_VRAT;
						ST_VRAT: state_d = ST_S;
						ST_S: state_d = ST_GRAT;
						ST_GRAT: state_d = ST_G;
						ST_G: state_d = ST_F;
						ST_F: state_d = ST_T;
						ST_T: state_d = ST_T2;
						ST_T2: state_d = ST_DRAT;
						ST_DRAT: state_d = ST_D;
						ST_D: state_d = ST_PHI;
						ST_PHI: state_d = ST_ACC;
						ST_ACC: state_d = ST_J_NEXT;
						ST_QX: state_d = ST_MAG;
						ST_MAG: state_d = ST_DONE;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			default: begin
				alu_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q <= 3'd0;
			vf_q <= 16'd1;
			df_q <= 16'd1;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			prop_q <= '0;
			loop_q <= '0;
			op_run_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TARGET: tgt_q <= cfg_data[2:0];
					CFG_VISC_FLOOR: vf_q <= cfg_data;
					CFG_DEN_FLOOR: df_q <= cfg_data;
					default: tgt_q <= tgt_q;
				endcase
			end

			if (accept) begin
				if (store_we) begin
					if (cnt_q == tgt_ext) begin
						prop_q <= property_value;
					end
					cnt_q <= cnt_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end

			if (alu_req.start) begin
				op_run_q <= 1'b1;
			end else if (alu_rsp.done) begin
				op_run_q <= 1'b0;
			end

			unique case (state_q)
				ST_START: loop_q <= '0;
				ST_CHECK: loop_q <= tgt_ext;
				ST_SUM_OP, ST_ACC: begin
					if (alu_rsp.done) begin
						loop_q <= loop_q + CNT_W'(1);
					end
				end
				ST_XI: begin
					if (alu_rsp.done) begin
						loop_q <= '0;
					end
				end
				ST_J_NEXT: begin
					if ((loop_q != cnt_q) && (loop_q == tgt_ext)) begin
						loop_q <= loop_q + CNT_W'(1);
					end
				end
				default: loop_q <= loop_q;
			endcase

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
				cnt_q <= '0;
				ovf_q <= 1'b0;
				prop_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			contribution_q <= res_q;
			degenerate_q <= deg_q;
		end
		unique case (state_q)
			ST_START: begin
				sum_q <= '0;
				res_q <= '0;
				deg_q <= 1'b1;
			end
			ST_CHECK: begin
				res_q <= '0;
				deg_q <= (sum_q == 64'd0);
			end
			default: begin
				if (alu_rsp.done) begin
					unique case (state_q)
						ST_SUM_OP: sum_q <= sum_q + alu_rsp.result[63:0];
						ST_NI: begin
							tmp_q <= alu_rsp.result[63:0];
							mi_q <= w_eff;
							mui_q <= st_visc;
						end
						ST_XI: begin
							xi_q <= alu_rsp.result[63:0];
							den_q <= {16'd0, alu_rsp.result[63:16]};
						end
						ST_XJ: xj_q <= alu_rsp.result[63:0];
						ST_S: s_q <= alu_rsp.result[63:0];
						ST_F: f_q <= alu_rsp.result[63:0];
						ST_T: tmp_q <= ONE_Q16 + alu_rsp.result[79:16];
						ST_T2: t2_q <= alu_rsp.result[79:16];
						ST_ACC: den_q <= den_q + alu_rsp.result[95:32];
						ST_QX: tmp_q <= alu_rsp.result[79:16];
						ST_MAG: begin
							res_q <= signed_res;
							deg_q <= 1'b0;
						end
						default: tmp_q <= alu_rsp.result[63:0];
					endcase
				end
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign contribution = contribution_q;
	assign degenerate = degenerate_q;

	`WMC_ASSERT_NOW(a_alu_start_idle, alu_req.start, !alu_rsp.busy, "Serial unit started while busy.")
	`WMC_ASSERT_NOW(a_alu_done_owned, alu_rsp.done, op_run_q, "Serial unit finished with no operation pending.")
	`WMC_ASSERT_NOW(a_degenerate_zero, out_valid_q && degenerate_q, contribution_q == 32'd0, "Degenerate result carries a nonzero contribution.")
	`WMC_ASSERT_NEXT(a_cell_cleared, (state_q == ST_DONE) && out_free, (cnt_q == '0) && !ovf_q, "Cell state not cleared after a result.")

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the Wilke mixing contribution unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wmc_pkg::*;

	typedef struct {
		logic [15:0] y;
		logic [15:0] w;
		logic [31:0] mu;
		logic [31:0] q;
		logic last;
	} species_t;

	typedef struct {
		logic [31:0] contrib;
		logic degen;
	} result_t;

	localparam int WATCHDOG_LIMIT = 200000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [15:0] mass_fraction = 0;
	logic [15:0] mol_weight = 0;
	logic [31:0] viscosity = 0;
	logic signed [31:0] property_value = 0;
	logic last_species = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] contribution;
	logic degenerate;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_TARGET;
	logic [15:0] cfg_data = 0;

	wilke_mixing_contribution_unit DUT (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	// Predictor state.
	logic [2:0] m_target = 0;
	logic [15:0] m_vfloor = 1;
	logic [15:0] m_dfloor = 1;
	logic [15:0] m_y[MAX_SPECIES];
	logic [15:0] m_w[MAX_SPECIES];
	logic [31:0] m_mu[MAX_SPECIES];
	logic [31:0] m_q = 0;
	int m_count = 0;
	bit m_over = 0;

	result_t expected_q[$];
	int errors = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	bit hold_off = 0;
	bit burst_mode = 1;

	function automatic logic [63:0] sqrt64(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] frac_div(logic [63:0] a, logic [63:0] b, int sh);
		logic [63:0] q, r;
		q = a / b;
		r = a % b;
		for (int k = 0; k < sh; k++) begin
			q <<= 1;
			r <<= 1;
			if (r >= b) begin
				r -= b;
				q |= 1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] weight(int k);
		return m_w[k] == 0 ? 64'd1 : {48'd0, m_w[k]};
	endfunction

	function automatic logic [63:0] phi_term(int i, int j, logic [63:0] vf);
		logic [63:0] mi, mj, muj, s, g, f, t, th, tl, t2, d;
		mi = weight(i);
		mj = weight(j);
		muj = {32'd0, m_mu[j]};
		if (muj < vf) muj = vf;
		s = sqrt64(({32'd0, m_mu[i]} << 32) / muj);
		g = sqrt64((mj << 32) / mi);
		f = sqrt64(g << 16);
		t = 64'd65536 + ((s * f) >> 16);
		th = t >> 16;
		tl = t & 64'hFFFF;
		t2 = ((th * th) << 16) + 64'd2 * th * tl + ((tl * tl) >> 16);
		d = sqrt64((64'd8 << 32) + ((mi << 35) / mj));
		return frac_div(t2, d, 16);
	endfunction

	function automatic result_t cell_result();
		result_t r;
		logic [63:0] n[MAX_SPECIES];
		logic [63:0] sum, xi, xj, den, ph, qmag, mag, lim, vf, df;
		bit neg;
		r.contrib = 0;
		r.degen = 0;
		sum = 0;
		if (m_over) begin
			r.degen = 1;
			return r;
		end
		for (int k = 0; k < m_count; k++) begin
			n[k] = ({48'd0, m_y[k]} << 32) / weight(k);
			sum += n[k];
		end
		if (sum == 0) begin
			r.degen = 1;
			return r;
		end
		if (m_target >= m_count) return r;
		vf = m_vfloor == 0 ? 64'd1 : {48'd0, m_vfloor};
		df = m_dfloor == 0 ? 64'd1 : {48'd0, m_dfloor};
		xi = frac_div(n[m_target], sum, 32);
		den = xi >> 16;
		for (int k = 0; k < m_count; k++) begin
			if (k == m_target) continue;
			xj = frac_div(n[k], sum, 32);
			ph = phi_term(m_target, k, vf);
			den += xj * (ph >> 32) + ((xj * (ph & 64'hFFFFFFFF)) >> 32);
		end
		if (den < df) den = df;
		neg = m_q[31];
		qmag = neg ? {32'd0, -m_q} : {32'd0, m_q};
		if (neg && qmag == 0) qmag = 64'h80000000;
		mag = ((qmag * xi) >> 16) / den;
		lim = neg ? 64'h80000000 : 64'h7FFFFFFF;
		if (mag > lim) mag = lim;
		r.contrib = neg ? -mag[31:0] : mag[31:0];
		return r;
	endfunction

	function automatic void predict_species(species_t s);
		if (m_count < MAX_SPECIES) begin
			m_y[m_count] = s.y;
			m_w[m_count] = s.w;
			m_mu[m_count] = s.mu;
			if (m_count == m_target) m_q = s.q;
			m_count++;
		end else begin
			m_over = 1;
		end
		if (s.last) begin
			expected_q.push_back(cell_result());
			m_count = 0;
			m_over = 0;
			m_q = 0;
		end
	endfunction

	// Called at a falling edge; leaves in_valid high so that requests can follow back to back.
	task automatic send_species(species_t s);
		int gap;
		if (!burst_mode) begin
			gap = $urandom_range(0, 4);
			if (gap != 0) begin
				in_valid <= 0;
				repeat (gap) @(negedge clk);
			end
		end
		if ($urandom_range(0, 15) == 0) burst_mode = ~burst_mode;
		in_valid <= 1;
		mass_fraction <= s.y;
		mol_weight <= s.w;
		viscosity <= s.mu;
		property_value <= s.q;
		last_species <= s.last;
		while (in_stall) @(negedge clk);
		@(posedge clk);
		predict_species(s);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		in_valid <= 0;
		wait (expected_q.size() == 0);
		@(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == CFG_TARGET) m_target = val[2:0];
		else if (idx == CFG_VISC_FLOOR) m_vfloor = val;
		else if (idx == CFG_DEN_FLOOR) m_dfloor = val;
	endtask

	function automatic species_t rand_species(bit last);
		species_t s;
		s.y = 16'($urandom());
		s.w = 16'($urandom());
		s.mu = $urandom();
		s.q = $urandom();
		s.last = last;
		if ($urandom_range(0, 9) == 0) s.y = 0;
		if ($urandom_range(0, 19) == 0) s.w = 0;
		if ($urandom_range(0, 9) == 0) s.mu = $urandom_range(0, 3);
		return s;
	endfunction

	task automatic send_cell(int n);
		for (int k = 0; k < n; k++) send_species(rand_species(k == n - 1));
	endtask

	task automatic test_extremes();
		species_t s;
		s = '{16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 1'b0};
		send_species(s);
		s = '{16'h0001, 16'h0001, 32'h0, 32'h80000000, 1'b1};
		send_species(s);
		s = '{16'h8000, 16'h0000, 32'h00010000, 32'h80000000, 1'b1};
		send_species(s);
		s = '{16'h0000, 16'h1000, 32'h00010000, 32'hFFFFFFFF, 1'b0};
		send_species(s);
		s = '{16'h0000, 16'h2000, 32'h00020000, 32'h00010000, 1'b1};
		send_species(s);
	endtask

	task automatic test_overflow();
		for (int k = 0; k < MAX_SPECIES + 2; k++)
			send_species(rand_species(k == MAX_SPECIES + 1));
		send_cell(MAX_SPECIES);
	endtask

	task automatic test_target_missing();
		write_reg(CFG_TARGET, 16'd7);
		send_cell(3);
		send_cell(MAX_SPECIES);
	endtask

	task automatic test_floors();
		write_reg(CFG_VISC_FLOOR, 16'hFFFF);
		write_reg(CFG_DEN_FLOOR, 16'hFFFF);
		write_reg(CFG_TARGET, 16'd0);
		send_cell(2);
		send_cell(4);
		write_reg(CFG_VISC_FLOOR, 16'd0);
		write_reg(CFG_DEN_FLOOR, 16'd0);
		send_cell(3);
	endtask

	task automatic test_random_cells();
		int sent;
		sent = 0;
		for (int phase = 0; phase < 6; phase++) begin
			write_reg(CFG_TARGET, 16'($urandom_range(0, 7)));
			write_reg(CFG_VISC_FLOOR, 16'($urandom_range(1, 65535)));
			write_reg(CFG_DEN_FLOOR, phase == 0 ? 16'd1 : 16'($urandom_range(1, 65535)));
			while (sent < (phase + 1) * 270) begin
				int n;
				n = $urandom_range(0, 19) == 0 ? $urandom_range(9, 10)
					: $urandom_range(1, MAX_SPECIES);
				send_cell(n);
				sent += n;
			end
		end
	endtask

	task automatic test_backpressure();
		hold_off = 1;
		send_cell(2);
		send_cell(2);
		send_cell(3);
		wait (!hold_off);
	endtask

	// Receiver stall pattern plus one long hold-off.
	initial begin
		int hold;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1;
				hold = 0;
				while (hold < 8000) begin
					@(negedge clk);
					hold++;
				end
				out_stall <= 0;
				hold_off = 0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 30) && ($urandom_range(0, 3) != 0);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			idle_cycles <= 0;
			if (expected_q.size() == 0) begin
				errors++;
				if (++mismatches <= 10) $display("Unexpected result %h", contribution);
			end else begin
				result_t e;
				e = expected_q.pop_front();
				if (e.contrib !== contribution || e.degen !== degenerate) begin
					errors++;
					if (++mismatches <= 10)
						$display("Mismatch: expected %h/%b got %h/%b",
							e.contrib, e.degen, contribution, degenerate);
				end
			end
		end else if (arst_n && in_valid && !in_stall) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		test_extremes();
		test_overflow();
		test_target_missing();
		test_floors();
		test_backpressure();
		test_random_cells();
		in_valid <= 0;
		wait (expected_q.size() == 0);
		repeat (200) @(negedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
